/* hdl/cartridge_rom_bank_mapper_unit_macros.svh */
// Assertion macros shared by the cartridge ROM bank mapper RTL.
`ifndef CARTRIDGE_ROM_BANK_MAPPER_UNIT_MACROS_SVH
`define CARTRIDGE_ROM_BANK_MAPPER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbm implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbm next-cycle check failed");
`else
`define CBM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/cbm_pkg.sv */
// Types and constants of the cartridge ROM bank mapper.
package cbm_pkg;

    localparam int unsigned AddrW = 15;
    localparam int unsigned DataW = 8;
    localparam int unsigned BankW = 9;
    localparam int unsigned RomW  = 23;
    localparam int unsigned TypeW = 3;

    // Controller type codes.
    localparam logic [TypeW-1:0] CTRL_ROM_ONLY  = 3'd0;
    localparam logic [TypeW-1:0] CTRL_MBC1_16_8 = 3'd1;
    localparam logic [TypeW-1:0] CTRL_MBC1_4_32 = 3'd2;
    localparam logic [TypeW-1:0] CTRL_MBC2      = 3'd3;
    localparam logic [TypeW-1:0] CTRL_MBC3      = 3'd4;
    localparam logic [TypeW-1:0] CTRL_MBC5      = 3'd5;

    // Request kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Bank register value after reset.
    localparam logic [BankW-1:0] BANK_RESET = 9'd1;

    // One CPU bus access.
    typedef struct packed {
        logic             req_type;
        logic [AddrW-1:0] bus_address;
        logic [DataW-1:0] write_value;
    } access_t;

endpackage

/* hdl/cartridge_rom_bank_mapper_unit.sv */
// Top level of the cartridge ROM bank mapper.
//
// The slave stream carries one CPU access to cartridge space per transfer:
// tuser is the request kind (read or write), tdata the bus address and the
// written byte. The master stream returns one transfer per access with the
// physical ROM byte address (zero for writes) and the bank after the access.
// The user writes the controller type through cfg_we and cfg_wdata only while
// idle; the block itself does not enforce it. An access is held in an input
// register, then mapped and applied to the bank register as it moves into an
// output register, when that is free or drains; the output register holds the
// result. Throughput is one access per cycle while the receiver does not stall;
// the bank register update sits between the input and output registers.
// Reset sets the controller type to ROM only and the bank register to one.
// When the receiver stalls, the output register holds its result, the input
// register still takes one more access, and then tready drops.
`include "cartridge_rom_bank_mapper_unit_macros.svh"

module cartridge_rom_bank_mapper_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,       // controller_type
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,         // bus_address[14:0], write_value[22:15], zero
    input  logic        s_tuser,         // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata          // rom_address[22:0], current_bank[31:23]
);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    cbm_pkg::access_t          in_access_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [cbm_pkg::RomW-1:0]  out_rom_reg;
    logic [cbm_pkg::BankW-1:0] out_bank_reg;
    logic                      advance;
    logic                      in_xfer;
    logic [cbm_pkg::BankW-1:0] bank;
    logic [cbm_pkg::BankW-1:0] bank_next;
    logic [cbm_pkg::RomW-1:0]  rom_address;

    // Handshake: the stage moves when the output register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // Bank and configuration state.
    cbm_bank_ctrl u_bank_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .update    (advance),
        .access    (in_access_reg),
        .bank      (bank),
        .bank_next (bank_next)
    );

    // Address mapping with the bank as it stands before this access.
    cbm_addr_map u_addr_map (
        .access      (in_access_reg),
        .bank        (bank),
        .rom_address (rom_address)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_access_reg.req_type    <= s_tuser;
            in_access_reg.bus_address <= s_tdata[14:0];
            in_access_reg.write_value <= s_tdata[22:15];
        end
        if (advance)
        begin
            out_rom_reg  <= rom_address;
            out_bank_reg <= bank_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bank_reg, out_rom_reg};

    // A write returns a zero ROM address.
    `CBM_ASSERT_NEXT(a_write_zero_addr, clk, rst_n,
        advance && (in_access_reg.req_type == cbm_pkg::REQ_WRITE), m_tdata[22:0] == 23'd0)
    // A read of the fixed window maps straight through.
    `CBM_ASSERT_NEXT(a_fixed_window, clk, rst_n,
        advance && (in_access_reg.req_type == cbm_pkg::REQ_READ)
            && !in_access_reg.bus_address[14],
        (m_tdata[22:15] == 8'd0) && (m_tdata[14:0] == $past(in_access_reg.bus_address)))
    // The reported bank is the bank register after the access.
    `CBM_ASSERT_NEXT(a_bank_reported, clk, rst_n, advance, m_tdata[31:23] == bank)
    // The bank only changes when an access goes through the stage.
    `CBM_ASSERT_NEXT(a_bank_quiet, clk, rst_n, !advance, bank == $past(bank))

endmodule

/* hdl/cbm_bank_ctrl.sv */
// Controller type register and ROM bank register with its write rules.
module cbm_bank_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cbm_pkg::TypeW-1:0]  cfg_wdata,
    input  logic                       update,
    input  cbm_pkg::access_t           access,
    output logic [cbm_pkg::BankW-1:0]  bank,
    output logic [cbm_pkg::BankW-1:0]  bank_next
);

    logic [cbm_pkg::TypeW-1:0] ctrl_type_reg;
    logic [cbm_pkg::BankW-1:0] bank_reg;
    logic [cbm_pkg::BankW-1:0] write_bank;
    logic                      low_range;
    logic                      upper_range;
    logic                      mbc5_low;
    logic                      mbc5_high;
    logic [4:0]                field5;
    logic [3:0]                field4;
    logic [6:0]                field7;

    // Address decode of the control ranges.
    assign low_range   = (access.bus_address[14:13] == 2'b01);
    assign upper_range = (access.bus_address[14:13] == 2'b10);
    assign mbc5_low    = (access.bus_address[14:12] == 3'b010);
    assign mbc5_high   = (access.bus_address[14:12] == 3'b011);

    // Masked bank fields; a zero written to the low bank becomes one.
    assign field5 = (access.write_value[4:0] == 5'd0) ? 5'd1 : access.write_value[4:0];
    assign field4 = (access.write_value[3:0] == 4'd0) ? 4'd1 : access.write_value[3:0];
    assign field7 = (access.write_value[6:0] == 7'd0) ? 7'd1 : access.write_value[6:0];

    // Bank value that a write leaves, by controller type.
    always_comb
    begin
        write_bank = bank_reg;
        unique case (ctrl_type_reg)
            cbm_pkg::CTRL_MBC1_16_8, cbm_pkg::CTRL_MBC1_4_32:
            begin
                if (low_range)
                begin
                    write_bank = {1'b0, bank_reg[7:5], field5};
                end
                else if (upper_range && (ctrl_type_reg == cbm_pkg::CTRL_MBC1_16_8))
                begin
                    write_bank = {2'b00, access.write_value[1:0], bank_reg[4:0]};
                end
            end
            cbm_pkg::CTRL_MBC2:
            begin
                if (low_range)
                begin
                    write_bank = {5'd0, field4};
                end
            end
            cbm_pkg::CTRL_MBC3:
            begin
                if (low_range)
                begin
                    write_bank = {2'd0, field7};
                end
            end
            cbm_pkg::CTRL_MBC5:
            begin
                if (mbc5_low)
                begin
                    write_bank = {bank_reg[8], access.write_value};
                end
                else if (mbc5_high)
                begin
                    write_bank = {access.write_value[0], bank_reg[7:0]};
                end
            end
            default:
            begin
                write_bank = bank_reg;
            end
        endcase
    end

    // Only a write that goes through the stage changes the bank.
    assign bank_next = (update && (access.req_type == cbm_pkg::REQ_WRITE))
                       ? write_bank : bank_reg;

    // Configuration and bank registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_type_reg <= cbm_pkg::CTRL_ROM_ONLY;
            bank_reg      <= cbm_pkg::BANK_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                ctrl_type_reg <= cfg_wdata;
            end
            bank_reg <= bank_next;
        end
    end

    assign bank = bank_reg;

endmodule

/* hdl/cbm_addr_map.sv */
// Maps a CPU read address through the current bank to a ROM byte address.
module cbm_addr_map (
    input  cbm_pkg::access_t          access,
    input  logic [cbm_pkg::BankW-1:0] bank,
    output logic [cbm_pkg::RomW-1:0]  rom_address
);

    // Writes give zero; the upper window takes the bank as the high bits.
    always_comb
    begin
        priority if (access.req_type == cbm_pkg::REQ_WRITE)
        begin
            rom_address = '0;
        end
        else if (access.bus_address[14])
        begin
            rom_address = {bank, access.bus_address[13:0]};
        end
        else
        begin
            rom_address = {8'd0, access.bus_address};
        end
    end

endmodule

/* bench/cartridge_rom_bank_mapper_unit_tb.sv */
// Self-checking testbench for the cartridge ROM bank mapper: directed and random bus accesses.
module cartridge_rom_bank_mapper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Controller code outside the defined set; the block treats it as ROM only.
    localparam logic [cbm_pkg::TypeW-1:0] CTRL_UNUSED_HI = 3'd7;
    localparam logic [cbm_pkg::TypeW-1:0] CTRL_UNUSED_LO = 3'd6;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 128;
    localparam int MAX_REPORTED = 10;

    // One expected result, laid out as on m_tdata: bank in the upper bits.
    typedef struct packed {
        logic [cbm_pkg::BankW-1:0] current_bank;
        logic [cbm_pkg::RomW-1:0]  rom_address;
    } mapped_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Predictor state and expected results in arrival order.
    logic [cbm_pkg::TypeW-1:0] ctrl_model = cbm_pkg::CTRL_ROM_ONLY;
    logic [cbm_pkg::BankW-1:0] bank_model = cbm_pkg::BANK_RESET;
    mapped_t                   pending_results[$];

    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 0;

    cartridge_rom_bank_mapper_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Counts a failure and prints the first few of them.
    function automatic void report_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
            $display("mismatch %0d at cycle %0d: %s", fail_count, cycle_count, what);
    endfunction

    // Applies one access to the predicted bank register and queues its result.
    function automatic void map_access(input logic req,
                                       input logic [cbm_pkg::AddrW-1:0] addr,
                                       input logic [cbm_pkg::DataW-1:0] val);
        logic [cbm_pkg::BankW-1:0] b;
        logic [4:0]                lo5;
        logic [3:0]                lo4;
        logic [6:0]                lo7;
        logic                      low_range;
        mapped_t                   res;

        b = bank_model;
        low_range = (addr >= 15'h2000) && (addr <= 15'h3FFF);
        // A zero bank field is promoted to one on the older controller types.
        lo5 = (val[4:0] == 5'd0) ? 5'd1 : val[4:0];
        lo4 = (val[3:0] == 4'd0) ? 4'd1 : val[3:0];
        lo7 = (val[6:0] == 7'd0) ? 7'd1 : val[6:0];
        res.rom_address = '0;

        if (req == cbm_pkg::REQ_WRITE)
        begin
            case (ctrl_model)
                cbm_pkg::CTRL_MBC1_16_8, cbm_pkg::CTRL_MBC1_4_32:
                begin
                    if (low_range)
                        b = {1'b0, b[7:5], lo5};
                    if (ctrl_model == cbm_pkg::CTRL_MBC1_16_8
                        && addr >= 15'h4000 && addr <= 15'h5FFF)
                        b = {2'b00, val[1:0], b[4:0]};
                end
                cbm_pkg::CTRL_MBC2:
                    if (low_range)
                        b = {5'd0, lo4};
                cbm_pkg::CTRL_MBC3:
                    if (low_range)
                        b = {2'd0, lo7};
                cbm_pkg::CTRL_MBC5:
                begin
                    if (addr >= 15'h2000 && addr <= 15'h2FFF)
                        b = {b[8], val};
                    if (addr >= 15'h3000 && addr <= 15'h3FFF)
                        b = {val[0], b[7:0]};
                end
                default:
                    b = bank_model;
            endcase
            bank_model = b;
        end
        else if (addr >= 15'h4000)
            res.rom_address = {bank_model, addr[13:0]};
        else
            res.rom_address = {8'd0, addr};

        res.current_bank = bank_model;
        pending_results.push_back(res);
    endfunction

    // Result checker and receiver stall pattern.
    int       rx_window = 0;
    int       rx_mode = 0;
    int       rx_phase = 0;
    logic [7:0] rx_pattern = 8'hFF;

    always @(posedge clk)
    begin
        mapped_t got;
        mapped_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
                report_failure($sformatf("unexpected result rom=%h bank=%h",
                                         got.rom_address, got.current_bank));
            else
            begin
                want = pending_results.pop_front();
                if (got.rom_address !== want.rom_address)
                    report_failure($sformatf("rom_address expected %h got %h",
                                             want.rom_address, got.rom_address));
                if (got.current_bank !== want.current_bank)
                    report_failure($sformatf("current_bank expected %h got %h",
                                             want.current_bank, got.current_bank));
            end
        end

        // Pick a new stall mode when the current window runs out, always-ready among them.
        if (rx_window == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_window = $urandom_range(20, 80);
            rx_pattern = 8'($urandom_range(1, 255));
        end
        rx_window--;
        rx_phase = (rx_phase + 1) % 8;
        if (!rst_n)
            m_tready <= 1'b0;
        else
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_pattern[rx_phase];
            endcase
    end

    // Sends one access in bursts separated by random gaps; returns after the transfer.
    task automatic send_access(input logic req, input logic [cbm_pkg::AddrW-1:0] addr,
                               input logic [cbm_pkg::DataW-1:0] val);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, val, addr};
        do
            @(posedge clk);
        while (!s_tready);
        map_access(req, addr, val);
    endtask

    // Writes the controller type once every outstanding result has come back.
    task automatic set_controller_type(input logic [cbm_pkg::TypeW-1:0] code);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we <= 1'b0;
        ctrl_model = code;
    endtask

    // Reset state: straight reads, high window at bank one, writes ignored.
    task automatic test_rom_only_after_reset();
        send_access(cbm_pkg::REQ_READ, 15'h0000, 8'h00);
        send_access(cbm_pkg::REQ_READ, 15'h7FFF, 8'hFF);
        send_access(cbm_pkg::REQ_WRITE, 15'h2000, 8'hFF);
        send_access(cbm_pkg::REQ_READ, 15'h4000, 8'h00);
    endtask

    // Both MBC1 variants: low field with zero promotion, upper bits only on 16/8.
    task automatic test_mbc1();
        set_controller_type(cbm_pkg::CTRL_MBC1_16_8);
        send_access(cbm_pkg::REQ_WRITE, 15'h2000, 8'h00);
        send_access(cbm_pkg::REQ_WRITE, 15'h3FFF, 8'hFF);
        send_access(cbm_pkg::REQ_WRITE, 15'h4000, 8'h03);
        send_access(cbm_pkg::REQ_READ, 15'h7FFF, 8'h00);
        send_access(cbm_pkg::REQ_WRITE, 15'h5FFF, 8'h00);
        set_controller_type(cbm_pkg::CTRL_MBC1_4_32);
        send_access(cbm_pkg::REQ_WRITE, 15'h4000, 8'h03);
        send_access(cbm_pkg::REQ_WRITE, 15'h2000, 8'h20);
    endtask

    // MBC2 and MBC3 loads, each with a zero that is promoted to one.
    task automatic test_mbc2_mbc3();
        set_controller_type(cbm_pkg::CTRL_MBC2);
        send_access(cbm_pkg::REQ_WRITE, 15'h3000, 8'hF0);
        send_access(cbm_pkg::REQ_WRITE, 15'h2000, 8'hFF);
        set_controller_type(cbm_pkg::CTRL_MBC3);
        send_access(cbm_pkg::REQ_WRITE, 15'h2000, 8'h80);
        send_access(cbm_pkg::REQ_WRITE, 15'h2000, 8'h7F);
        send_access(cbm_pkg::REQ_READ, 15'h4000, 8'h00);
    endtask

    // MBC5: bank zero in the high window, bit 8, the top ROM byte, ignored ranges.
    task automatic test_mbc5();
        set_controller_type(cbm_pkg::CTRL_MBC5);
        send_access(cbm_pkg::REQ_WRITE, 15'h2000, 8'h00);
        send_access(cbm_pkg::REQ_READ, 15'h4000, 8'h00);
        send_access(cbm_pkg::REQ_WRITE, 15'h3000, 8'h01);
        send_access(cbm_pkg::REQ_WRITE, 15'h2FFF, 8'hFF);
        send_access(cbm_pkg::REQ_READ, 15'h7FFF, 8'h00);
        send_access(cbm_pkg::REQ_WRITE, 15'h1FFF, 8'h12);
        send_access(cbm_pkg::REQ_WRITE, 15'h6000, 8'h34);
    endtask

    // An unused code behaves as ROM only and keeps the bank left by MBC5.
    task automatic test_unused_code();
        set_controller_type(CTRL_UNUSED_HI);
        send_access(cbm_pkg::REQ_WRITE, 15'h2000, 8'h05);
        send_access(cbm_pkg::REQ_READ, 15'h5555, 8'hAA);
    endtask

    // Random reads and writes, the writes aimed mostly at the control ranges, one phase per listed code.
    task automatic test_random_traffic();
        logic [cbm_pkg::TypeW-1:0] phase_codes[12];
        logic [cbm_pkg::AddrW-1:0] addr;
        logic [cbm_pkg::DataW-1:0] val;
        logic                      req;
        int                        region;

        phase_codes = '{cbm_pkg::CTRL_ROM_ONLY, cbm_pkg::CTRL_MBC1_16_8,
                        cbm_pkg::CTRL_MBC1_4_32, cbm_pkg::CTRL_MBC2,
                        cbm_pkg::CTRL_MBC3, cbm_pkg::CTRL_MBC5, CTRL_UNUSED_LO,
                        CTRL_UNUSED_HI, cbm_pkg::CTRL_MBC5, cbm_pkg::CTRL_MBC1_16_8,
                        cbm_pkg::CTRL_MBC3, cbm_pkg::CTRL_MBC1_4_32};
        foreach (phase_codes[p])
        begin
            set_controller_type(phase_codes[p]);
            repeat (PHASE_ITEMS)
            begin
                val = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 45)
                begin
                    req = cbm_pkg::REQ_READ;
                    addr = 15'($urandom_range(0, 16'h7FFF));
                    // Now and then hit the edges of the two windows.
                    if ($urandom_range(0, 7) == 0)
                        case ($urandom_range(0, 3))
                            0: addr = 15'h0000;
                            1: addr = 15'h3FFF;
                            2: addr = 15'h4000;
                            default: addr = 15'h7FFF;
                        endcase
                end
                else
                begin
                    req = cbm_pkg::REQ_WRITE;
                    region = $urandom_range(0, 4);
                    case (region)
                        0: addr = 15'($urandom_range(16'h2000, 16'h2FFF));
                        1: addr = 15'($urandom_range(16'h3000, 16'h3FFF));
                        2: addr = 15'($urandom_range(16'h4000, 16'h5FFF));
                        3: addr = 15'($urandom_range(16'h2000, 16'h3FFF));
                        default: addr = 15'($urandom_range(0, 16'h7FFF));
                    endcase
                    // Zero low bits exercise the promotion to bank one.
                    if ($urandom_range(0, 7) == 0)
                        val = val & 8'hE0;
                end
                send_access(req, addr, val);
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rom_only_after_reset();
        test_mbc1();
        test_mbc2_mbc3();
        test_mbc5();
        test_unused_code();
        test_random_traffic();

        // Drain, then allow time for any stray result.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_failure("results still outstanding at the end");

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* cartridge_rom_bank_mapper_unit.f */
+incdir+hdl
hdl/cbm_pkg.sv
hdl/cbm_bank_ctrl.sv
hdl/cbm_addr_map.sv
hdl/cartridge_rom_bank_mapper_unit.sv
bench/cartridge_rom_bank_mapper_unit_tb.sv
